@@ rtl/core/b64sd_pkg.sv @@
package b64sd_pkg;

  // Input item kinds
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // Padding character '='
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // Status codes on the final result
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_LEN = 1'b1;

  // Largest value the total_bytes field can show
  localparam logic [23:0] TOTAL_MAX = 24'hFF_FFFF;

  // Command queue between front and back
  localparam int FIFO_DEPTH     = 4;
  localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS  = $clog2(FIFO_DEPTH + 1);

  // One unit of work for the back end: up to three bytes (MSB first),
  // optionally followed by the end-of-message summary.
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  nbytes;
    logic        fin;
    logic        stat;
  } cmd_t;

  // Sextet lookup: {miss, value}; miss set for characters outside the alphabet
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = 7'h40;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b0, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = {1'b0, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2B) begin
      r = {1'b0, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b0, 6'd63};
    end
    return r;
  endfunction

endpackage

@@ rtl/core/b64sd_front.sv @@
module b64sd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              kind,
  input  logic [7:0]        char_in,
  input  logic              q_full,
  output logic              q_push,
  output b64sd_pkg::cmd_t   q_cmd
);

  logic [17:0] accum;
  logic [1:0]  cnt;
  logic        pad;
  logic        accept;
  logic [6:0]  lookup;
  logic        is_sym;
  logic        is_pad;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign lookup   = b64sd_pkg::sextet_of(char_in);
  assign is_pad   = (char_in == b64sd_pkg::PAD_CHAR);
  assign is_sym   = !lookup[6] && !pad;

  // Classify the item and build the command for the back end
  always_comb begin
    q_push = 1'b0;
    q_cmd  = '0;
    if (kind == b64sd_pkg::KIND_FLUSH) begin
      q_push   = accept;
      q_cmd.fin = 1'b1;
      unique case (cnt)
        2'd1: begin
          q_cmd.stat = b64sd_pkg::STATUS_BAD_LEN;
        end
        2'd2: begin
          q_cmd.word   = {accum[11:4], 16'h0};
          q_cmd.nbytes = 2'd1;
        end
        2'd3: begin
          q_cmd.word   = {accum[17:2], 8'h0};
          q_cmd.nbytes = 2'd2;
        end
        default: begin
          q_cmd.stat = b64sd_pkg::STATUS_OK;
        end
      endcase
    end else begin
      q_push       = accept && is_sym && (cnt == 2'd3);
      q_cmd.word   = {accum, lookup[5:0]};
      q_cmd.nbytes = 2'd3;
    end
  end

  // Advance the group accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      accum <= '0;
      cnt   <= '0;
      pad   <= 1'b0;
    end else if (accept) begin
      if (kind == b64sd_pkg::KIND_FLUSH) begin
        accum <= '0;
        cnt   <= '0;
        pad   <= 1'b0;
      end else if (!pad && is_pad) begin
        pad <= 1'b1;
      end else if (is_sym) begin
        if (cnt == 2'd3) begin
          accum <= '0;
          cnt   <= '0;
        end else begin
          accum <= {accum[11:0], lookup[5:0]};
          cnt   <= cnt + 2'd1;
        end
      end
    end
  end

endmodule

@@ rtl/core/b64sd_fifo.sv @@
module b64sd_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  b64sd_pkg::cmd_t   wr_cmd,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output b64sd_pkg::cmd_t   rd_cmd
);

  b64sd_pkg::cmd_t mem [b64sd_pkg::FIFO_DEPTH];
  logic [b64sd_pkg::FIFO_PTR_BITS-1:0] wr_ptr;
  logic [b64sd_pkg::FIFO_PTR_BITS-1:0] rd_ptr;
  logic [b64sd_pkg::FIFO_CNT_BITS-1:0] count;
  logic do_push;
  logic do_pop;

  assign full      = (count == b64sd_pkg::FIFO_CNT_BITS'(b64sd_pkg::FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign rd_cmd    = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/b64sd_back.sv @@
module b64sd_back #(
  parameter int COUNT_BITS = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  b64sd_pkg::cmd_t   q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              byte_valid,
  output logic              status,
  output logic [23:0]       total_bytes,
  output logic              last
);

  localparam int EXT_BITS = (COUNT_BITS > 24) ? COUNT_BITS : 24;

  logic                  busy;
  logic [23:0]           word;
  logic [1:0]            nleft;
  logic                  fin;
  logic                  stat;
  logic [COUNT_BITS-1:0] byte_cnt;
  logic [EXT_BITS-1:0]   cnt_ext;
  logic [23:0]           total_sat;
  logic                  out_free;
  logic                  advance;
  logic                  done;

  assign out_free  = !out_valid || !out_stall;
  assign advance   = busy && out_free;
  assign done      = (nleft == 2'd0) || (nleft == 2'd1 && !fin);
  assign q_pop     = q_valid && (!busy || (advance && done));
  assign cnt_ext   = EXT_BITS'(byte_cnt);
  assign total_sat = (cnt_ext > EXT_BITS'(b64sd_pkg::TOTAL_MAX)) ?
                     b64sd_pkg::TOTAL_MAX : cnt_ext[23:0];

  // Load and step the working command
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (q_pop) begin
      busy <= 1'b1;
    end else if (advance && done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      word  <= q_cmd.word;
      nleft <= q_cmd.nbytes;
      fin   <= q_cmd.fin;
      stat  <= q_cmd.stat;
    end else if (advance && nleft != 2'd0) begin
      word  <= {word[15:0], 8'h0};
      nleft <= nleft - 2'd1;
    end
  end

  // Count bytes of the message; clear on the summary
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_cnt <= '0;
    end else if (advance) begin
      if (nleft != 2'd0) begin
        if (byte_cnt != '1) begin
          byte_cnt <= byte_cnt + 1'b1;
        end
      end else begin
        byte_cnt <= '0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (nleft != 2'd0) begin
        out_byte    <= word[23:16];
        byte_valid  <= 1'b1;
        status      <= b64sd_pkg::STATUS_OK;
        total_bytes <= '0;
        last        <= 1'b0;
      end else begin
        out_byte    <= '0;
        byte_valid  <= 1'b0;
        status      <= stat;
        total_bytes <= total_sat;
        last        <= 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/base64_stream_decoder.sv @@
// Streaming base64 decoder, one character per input item.
// Input channel: in_valid/in_stall with kind (0 data, 1 end of message) and
// char_in. Characters outside the alphabet are skipped; after '=' the rest
// of the message is ignored.
// Output channel: out_valid/out_stall with out_byte, byte_valid, status,
// total_bytes and last. Every fourth alphabet character yields three byte
// items; an end-of-message item yields zero to two byte items and then one
// summary item with last set, status (1 = single leftover character) and the
// saturating byte count of the message.
// Throughput: one input item per cycle while in_stall is low; the output side
// delivers one item per cycle while out_stall is low.
// Each result passes through the command queue, the working command register
// and the output register before it is presented.
// A four-entry command queue separates the character front end from the
// byte emitter; in_stall rises only when that queue is full.
// Reset clears the decode state, the queue and the output valid flag. While
// out_stall is high the presented item holds and work backs up into the
// queue and then onto in_stall.
module base64_stream_decoder #(
  parameter int COUNT_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [7:0]  char_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        status,
  output logic [23:0] total_bytes,
  output logic        last
);

  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_valid;
  b64sd_pkg::cmd_t push_cmd;
  b64sd_pkg::cmd_t head_cmd;

  b64sd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .kind     (kind),
    .char_in  (char_in),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  b64sd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_cmd    (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .rd_cmd    (head_cmd)
  );

  b64sd_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_cmd       (head_cmd),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .status      (status),
    .total_bytes (total_bytes),
    .last        (last)
  );

endmodule
